FILE: hw/rtl/rmie_pkg.sv
// ----------------------------------------------------------------------------
// rmie_pkg
// Shared codes, widths and types of the register machine instruction executor.
// ----------------------------------------------------------------------------
package rmie_pkg;

    localparam int unsigned DATA_W          = 64;
    localparam int unsigned NUM_REGS        = 7;
    localparam int unsigned STACK_WORDS_DEF = 512;
    localparam int unsigned WORD_SHIFT      = 3;     // byte address to word index

    localparam logic [DATA_W-1:0] WORD_BYTES = DATA_W'(8);

    // opcodes
    localparam logic [3:0] OP_MOV  = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_CMP  = 4'd3;
    localparam logic [3:0] OP_JMP  = 4'd4;
    localparam logic [3:0] OP_JE   = 4'd5;
    localparam logic [3:0] OP_JNE  = 4'd6;
    localparam logic [3:0] OP_PUSH = 4'd7;
    localparam logic [3:0] OP_POP  = 4'd8;
    localparam logic [3:0] OP_CALL = 4'd9;
    localparam logic [3:0] OP_RET  = 4'd10;
    localparam logic [3:0] OP_HLT  = 4'd11;

    // register codes
    localparam logic [2:0] REG_RSP  = 3'd4;
    localparam logic [2:0] REG_RIP  = 3'd6;
    localparam logic [2:0] REG_NONE = 3'd7;

    // source kinds
    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_IMM  = 2'd1;
    localparam logic [1:0] SRC_REG  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DEST  = 3'd1;
    localparam logic [2:0] ST_BAD_OP    = 3'd2;
    localparam logic [2:0] ST_HALTED    = 3'd3;
    localparam logic [2:0] ST_BAD_SRC   = 3'd4;

    typedef logic [NUM_REGS-1:0][DATA_W-1:0] t_rf;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] next_rip;
        logic              zero_flag;
        logic              sign_flag;
    } t_result;

    // stack write request: rsp is the byte address after the decrement
    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] rsp;
        logic [DATA_W-1:0] data;
    } t_stk_wr;

endpackage

FILE: hw/rtl/rmie_stack_ram.sv
// ----------------------------------------------------------------------------
// rmie_stack_ram
// Stack word memory: one write and one registered read port, write data
// bypassed to the read port when both hit the same word in one cycle.
// ----------------------------------------------------------------------------
module rmie_stack_ram #(
    parameter int unsigned DEPTH = rmie_pkg::STACK_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  logic [rmie_pkg::DATA_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [rmie_pkg::DATA_W-1:0] o_rdata
);
    import rmie_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rmie_outq.sv
// ----------------------------------------------------------------------------
// rmie_outq
// Two-entry result queue that decouples execution from the output ready.
// ----------------------------------------------------------------------------
module rmie_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rmie_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output rmie_pkg::t_result o_data
);
    import rmie_pkg::*;

    t_result    r_buf [2];
    logic [1:0] r_cnt;
    logic       r_head;
    logic [1:0] n_cnt;
    logic       n_head;
    logic       pop;
    logic       wr_idx;

    assign pop    = (r_cnt != 2'd0) && i_ready;
    assign wr_idx = r_head ^ r_cnt[0];

    always_comb begin
        n_cnt  = r_cnt;
        n_head = r_head;
        if (pop) begin
            n_head = ~r_head;
        end
        unique case ({i_push, pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[wr_idx] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_head];

endmodule

FILE: hw/rtl/rmie_exec.sv
// ----------------------------------------------------------------------------
// rmie_exec
// Execute stage: holds the register file and flags, takes the stack word
// read at accept time and produces the result and the stack write.
// ----------------------------------------------------------------------------
module rmie_exec (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_cmd,
    input  logic [2:0]                  i_dest_register,
    input  logic [1:0]                  i_source_kind,
    input  logic [2:0]                  i_source_register,
    input  logic [rmie_pkg::DATA_W-1:0] i_immediate,
    input  logic                        i_q_full,
    input  logic [rmie_pkg::DATA_W-1:0] i_stk_rdata,
    output logic [rmie_pkg::DATA_W-1:0] o_rd_rsp,
    output rmie_pkg::t_stk_wr           o_stk_wr,
    output logic                        o_push,
    output rmie_pkg::t_result           o_result
);
    import rmie_pkg::*;

    // control
    logic              r_e_vld;
    logic              r_halted;
    logic              r_zf;
    logic              r_sf;
    t_rf               r_rf;
    // captured request
    logic [3:0]        r_cmd;
    logic [2:0]        r_dr;
    logic [1:0]        r_kind;
    logic [2:0]        r_sr;
    logic [DATA_W-1:0] r_imm;

    logic              in_fire;
    logic              e_fire;
    t_rf               n_rf;
    logic              n_zf;
    logic              n_sf;
    logic              n_halted;
    logic [2:0]        e_status;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] dval;
    logic [DATA_W-1:0] diff;
    logic              jumpish;
    t_stk_wr           e_wr;

    function automatic logic [DATA_W-1:0] reg_rd(input t_rf rf, input logic [2:0] idx);
        logic [DATA_W-1:0] v;
        v = '0;
        if (idx != REG_NONE) begin
            v = rf[idx];
        end
        return v;
    endfunction

    assign e_fire  = r_e_vld && !i_q_full;
    assign o_ready = !r_e_vld || e_fire;
    assign in_fire = i_valid && o_ready;

    assign jumpish = (r_cmd == OP_JMP) || (r_cmd == OP_JE) || (r_cmd == OP_JNE) ||
                     (r_cmd == OP_CALL) || (r_cmd == OP_RET);

    always_comb begin
        unique case (r_kind)
            SRC_IMM: src = r_imm;
            SRC_REG: src = reg_rd(r_rf, r_sr);
            default: src = '0;
        endcase
    end

    assign dval = reg_rd(r_rf, r_dr);
    assign diff = dval - src;

    always_comb begin
        n_rf     = r_rf;
        n_zf     = r_zf;
        n_sf     = r_sf;
        n_halted = r_halted;
        e_status = ST_OK;
        e_wr     = '0;
        priority if (r_halted) begin
            e_status = ST_HALTED;
        end else if (r_cmd == OP_HLT) begin
            n_halted = 1'b1;
            e_status = ST_HALTED;
        end else if ((r_dr == REG_NONE) && !jumpish) begin
            e_status = ST_BAD_DEST;
        end else if ((r_kind == SRC_REG) && (r_sr == REG_NONE)) begin
            e_status = ST_BAD_SRC;
        end else if (r_cmd > OP_HLT) begin
            e_status = ST_BAD_OP;
        end else begin
            unique case (r_cmd)
                OP_MOV: n_rf[r_dr] = src;
                OP_ADD: begin
                    n_rf[r_dr] = dval + src;
                    n_zf       = (n_rf[r_dr] == '0);
                    n_sf       = n_rf[r_dr][DATA_W-1];
                end
                OP_SUB: begin
                    n_rf[r_dr] = diff;
                    n_zf       = (diff == '0);
                    n_sf       = diff[DATA_W-1];
                end
                OP_CMP: begin
                    n_zf = (diff == '0);
                    n_sf = diff[DATA_W-1];
                end
                OP_JMP: n_rf[REG_RIP] = src;
                OP_JE: begin
                    if (r_zf) begin
                        n_rf[REG_RIP] = src;
                    end
                end
                OP_JNE: begin
                    if (!r_zf) begin
                        n_rf[REG_RIP] = src;
                    end
                end
                OP_PUSH: begin
                    // store the destination as seen after the decrement
                    n_rf[REG_RSP] = r_rf[REG_RSP] - WORD_BYTES;
                    e_wr.en       = 1'b1;
                    e_wr.rsp      = n_rf[REG_RSP];
                    e_wr.data     = n_rf[r_dr];
                end
                OP_POP: begin
                    n_rf[r_dr]    = i_stk_rdata;
                    n_rf[REG_RSP] = n_rf[REG_RSP] + WORD_BYTES;
                end
                OP_CALL: begin
                    n_rf[REG_RSP] = r_rf[REG_RSP] - WORD_BYTES;
                    e_wr.en       = 1'b1;
                    e_wr.rsp      = n_rf[REG_RSP];
                    e_wr.data     = r_rf[REG_RIP];
                    n_rf[REG_RIP] = src;
                end
                OP_RET: begin
                    n_rf[REG_RIP] = i_stk_rdata;
                    n_rf[REG_RSP] = r_rf[REG_RSP] + WORD_BYTES;
                end
                default: n_rf = r_rf;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld  <= 1'b0;
            r_halted <= 1'b0;
            r_zf     <= 1'b0;
            r_sf     <= 1'b0;
            r_rf     <= '0;
        end else begin
            if (e_fire) begin
                r_halted <= n_halted;
                r_zf     <= n_zf;
                r_sf     <= n_sf;
                r_rf     <= n_rf;
            end
            if (in_fire) begin
                r_e_vld <= 1'b1;
            end else if (e_fire) begin
                r_e_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= i_cmd;
            r_dr   <= i_dest_register;
            r_kind <= i_source_kind;
            r_sr   <= i_source_register;
            r_imm  <= i_immediate;
        end
    end

    // stack pointer that the next request sees
    assign o_rd_rsp = r_e_vld ? n_rf[REG_RSP] : r_rf[REG_RSP];

    always_comb begin
        o_stk_wr    = e_wr;
        o_stk_wr.en = e_wr.en && e_fire;
    end

    assign o_push              = e_fire;
    assign o_result.status     = e_status;
    assign o_result.dest_value = reg_rd(n_rf, r_dr);
    assign o_result.next_rip   = n_rf[REG_RIP];
    assign o_result.zero_flag  = n_zf;
    assign o_result.sign_flag  = n_sf;

`ifndef ASSERT_OFF
    a_wr_only_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stk_wr.en |-> (r_e_vld && !r_halted))
        else $error("stack write while idle or halted");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted state cleared");
    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_fire && r_halted) |-> (e_status == ST_HALTED))
        else $error("request executed while halted");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_vld && !e_fire) |=> (r_e_vld && $stable(r_cmd) && $stable(r_rf)))
        else $error("stalled request or state changed");
`endif

endmodule

FILE: hw/rtl/register_machine_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// register_machine_instruction_executor_top
// Executes one decoded instruction per request against seven 64-bit
// registers, zero/sign flags and a word-addressed stack memory.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  request  | i_valid / o_ready   | i_cmd, i_dest_register, i_source_kind,
//           |                     | i_source_register, i_immediate
//  result   | o_valid / i_ready   | o_status, o_dest_value, o_next_rip,
//           |                     | o_zero_flag, o_sign_flag
//
// One request per cycle sustained while the result queue is not full; a result
// passes through execute, using the stack word read at accept, then the queue.
// The stack read uses the stack pointer left by the request in execute; a
// write to the same word in that cycle is bypassed. A full two-entry result
// queue holds execute and drops o_ready; o_ready never depends on i_ready.
// Reset clears registers, flags and halt, not the stack. STACK_WORDS: power of 2.
// ----------------------------------------------------------------------------
module register_machine_instruction_executor_top #(
    parameter int unsigned STACK_WORDS = rmie_pkg::STACK_WORDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [3:0]                  i_cmd,
    input  logic [2:0]                  i_dest_register,
    input  logic [1:0]                  i_source_kind,
    input  logic [2:0]                  i_source_register,
    input  logic [rmie_pkg::DATA_W-1:0] i_immediate,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [rmie_pkg::DATA_W-1:0] o_dest_value,
    output logic [rmie_pkg::DATA_W-1:0] o_next_rip,
    output logic                        o_zero_flag,
    output logic                        o_sign_flag
);
    import rmie_pkg::*;

    localparam int unsigned AW = $clog2(STACK_WORDS);

    logic              q_full;
    logic              push;
    logic [DATA_W-1:0] stk_rdata;
    logic [DATA_W-1:0] rd_rsp;
    t_stk_wr           stk_wr;
    t_result           e_result;
    t_result           q_data;
    logic              in_fire;

    assign in_fire = i_valid && o_ready;

    rmie_exec u_exec (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_dest_register   (i_dest_register),
        .i_source_kind     (i_source_kind),
        .i_source_register (i_source_register),
        .i_immediate       (i_immediate),
        .i_q_full          (q_full),
        .i_stk_rdata       (stk_rdata),
        .o_rd_rsp          (rd_rsp),
        .o_stk_wr          (stk_wr),
        .o_push            (push),
        .o_result          (e_result)
    );

    rmie_stack_ram #(
        .DEPTH (STACK_WORDS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_wr.en),
        .i_waddr (stk_wr.rsp[WORD_SHIFT +: AW]),
        .i_wdata (stk_wr.data),
        .i_re    (in_fire),
        .i_raddr (rd_rsp[WORD_SHIFT +: AW]),
        .o_rdata (stk_rdata)
    );

    rmie_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (e_result),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (q_data)
    );

    assign o_status     = q_data.status;
    assign o_dest_value = q_data.dest_value;
    assign o_next_rip   = q_data.next_rip;
    assign o_zero_flag  = q_data.zero_flag;
    assign o_sign_flag  = q_data.sign_flag;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives decoded instructions into the executor and checks every result
// against an in-bench model of the registers, flags, halt state and stack.
// Directed tests cover arithmetic, jumps, stack wrap, error codes and halt;
// random programs mix stack call/return sequences with noise under random
// idling on both channels and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import rmie_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned BURST_ITEMS  = 40;

    // register, source and opcode codes the package leaves unnamed
    localparam logic [2:0] REG_RAX  = 3'd0;
    localparam logic [2:0] REG_RBX  = 3'd1;
    localparam logic [2:0] REG_RCX  = 3'd2;
    localparam logic [2:0] REG_RDX  = 3'd3;
    localparam logic [2:0] REG_RBP  = 3'd5;
    localparam logic [1:0] SRC_RSVD = 2'd3;
    localparam logic [3:0] OP_UNK_LO = 4'd12;
    localparam logic [3:0] OP_UNK_HI = 4'd15;

    typedef struct packed {
        logic [3:0]        cmd;
        logic [2:0]        dst;
        logic [1:0]        kind;
        logic [2:0]        srcr;
        logic [DATA_W-1:0] imm;
    } t_instr;

    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              i_valid           = 1'b0;
    logic              o_ready;
    logic [3:0]        i_cmd             = '0;
    logic [2:0]        i_dest_register   = '0;
    logic [1:0]        i_source_kind     = '0;
    logic [2:0]        i_source_register = '0;
    logic [DATA_W-1:0] i_immediate       = '0;
    logic              o_valid;
    logic              i_ready           = 1'b0;
    logic [2:0]        o_status;
    logic [DATA_W-1:0] o_dest_value;
    logic [DATA_W-1:0] o_next_rip;
    logic              o_zero_flag;
    logic              o_sign_flag;

    // machine state as seen by the predictor
    logic [DATA_W-1:0] arch_regs [NUM_REGS] = '{default: '0};
    logic              zf_st   = 1'b0;
    logic              sf_st   = 1'b0;
    logic              halt_st = 1'b0;
    logic [DATA_W-1:0] stack_mem   [STACK_WORDS_DEF];
    bit                stack_valid [STACK_WORDS_DEF];

    t_result machine_results_q [$];
    t_result want_res;

    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned stack_writes    = 0;
    int unsigned stack_reads     = 0;
    int unsigned errors          = 0;

    bit          send_idle_en = 1'b1;
    bit          recv_idle_en = 1'b1;
    int unsigned hold_req     = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;

    register_machine_instruction_executor_top #(
        .STACK_WORDS (STACK_WORDS_DEF)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_cmd             (i_cmd),
        .i_dest_register   (i_dest_register),
        .i_source_kind     (i_source_kind),
        .i_source_register (i_source_register),
        .i_immediate       (i_immediate),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_dest_value      (o_dest_value),
        .o_next_rip        (o_next_rip),
        .o_zero_flag       (o_zero_flag),
        .o_sign_flag       (o_sign_flag)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned slot_of(logic [DATA_W-1:0] sp);
        return int'((sp >> WORD_SHIFT) % 64'(STACK_WORDS_DEF));
    endfunction

    // Advance the model by one instruction and return the result it owes.
    function automatic t_result execute_instr(t_instr in);
        t_result           r;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] diff;
        logic              jump_class;
        jump_class = (in.cmd == OP_JMP || in.cmd == OP_JE || in.cmd == OP_JNE ||
                      in.cmd == OP_CALL || in.cmd == OP_RET);
        r.status = ST_OK;
        if (halt_st) begin
            r.status = ST_HALTED;
        end else if (in.cmd == OP_HLT) begin
            halt_st  = 1'b1;
            r.status = ST_HALTED;
        end else if (in.dst == REG_NONE && !jump_class) begin
            r.status = ST_BAD_DEST;
        end else if (in.kind == SRC_REG && in.srcr == REG_NONE) begin
            r.status = ST_BAD_SRC;
        end else if (in.cmd > OP_HLT) begin
            r.status = ST_BAD_OP;
        end else begin
            if (in.kind == SRC_IMM)
                src = in.imm;
            else if (in.kind == SRC_REG)
                src = arch_regs[in.srcr];
            else
                src = '0;
            case (in.cmd)
                OP_MOV: arch_regs[in.dst] = src;
                OP_ADD, OP_SUB, OP_CMP: begin
                    diff = (in.cmd == OP_ADD) ? arch_regs[in.dst] + src
                                              : arch_regs[in.dst] - src;
                    if (in.cmd != OP_CMP)
                        arch_regs[in.dst] = diff;
                    zf_st = (diff == '0);
                    sf_st = diff[DATA_W-1];
                end
                OP_JMP: arch_regs[REG_RIP] = src;
                OP_JE:  if (zf_st) arch_regs[REG_RIP] = src;
                OP_JNE: if (!zf_st) arch_regs[REG_RIP] = src;
                OP_PUSH, OP_CALL: begin
                    arch_regs[REG_RSP] = arch_regs[REG_RSP] - WORD_BYTES;
                    stack_mem[slot_of(arch_regs[REG_RSP])] =
                        (in.cmd == OP_PUSH) ? arch_regs[in.dst] : arch_regs[REG_RIP];
                    stack_valid[slot_of(arch_regs[REG_RSP])] = 1'b1;
                    stack_writes++;
                    if (in.cmd == OP_CALL)
                        arch_regs[REG_RIP] = src;
                end
                default: begin
                    // pop or return: read first, then release the word
                    if (in.cmd == OP_POP)
                        arch_regs[in.dst] = stack_mem[slot_of(arch_regs[REG_RSP])];
                    else
                        arch_regs[REG_RIP] = stack_mem[slot_of(arch_regs[REG_RSP])];
                    arch_regs[REG_RSP] = arch_regs[REG_RSP] + WORD_BYTES;
                    stack_reads++;
                end
            endcase
        end
        r.dest_value = (in.dst != REG_NONE) ? arch_regs[in.dst] : '0;
        r.next_rip   = arch_regs[REG_RIP];
        r.zero_flag  = zf_st;
        r.sign_flag  = sf_st;
        return r;
    endfunction

    function automatic t_instr instr(logic [3:0] cmd, logic [2:0] dst, logic [1:0] kind,
                                     logic [2:0] srcr, logic [DATA_W-1:0] imm);
        t_instr it;
        it.cmd  = cmd;
        it.dst  = dst;
        it.kind = kind;
        it.srcr = srcr;
        it.imm  = imm;
        return it;
    endfunction

    function automatic logic [2:0] pick_gpr();
        case ($urandom_range(0, 4))
            0:       return REG_RAX;
            1:       return REG_RBX;
            2:       return REG_RCX;
            3:       return REG_RDX;
            default: return REG_RBP;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, 63'($urandom)};
            3:       return 64'($urandom_range(0, 64)) << WORD_SHIFT;
            4:       return 64'($urandom_range(1, 16));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random instruction; halt is kept out since it ends the program for good.
    function automatic t_instr random_instr();
        t_instr      it;
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 12)      it.cmd = OP_MOV;
        else if (p < 24) it.cmd = OP_ADD;
        else if (p < 36) it.cmd = OP_SUB;
        else if (p < 46) it.cmd = OP_CMP;
        else if (p < 51) it.cmd = OP_JMP;
        else if (p < 57) it.cmd = OP_JE;
        else if (p < 63) it.cmd = OP_JNE;
        else if (p < 77) it.cmd = OP_PUSH;
        else if (p < 89) it.cmd = OP_POP;
        else if (p < 93) it.cmd = OP_CALL;
        else if (p < 97) it.cmd = OP_RET;
        else             it.cmd = 4'($urandom_range(OP_UNK_LO, OP_UNK_HI));
        p = $urandom_range(0, 99);
        if (p < 5)       it.dst = REG_NONE;
        else if (p < 12) it.dst = REG_RSP;
        else if (p < 18) it.dst = REG_RIP;
        else             it.dst = pick_gpr();
        p = $urandom_range(0, 99);
        if (p < 10)      it.kind = SRC_NONE;
        else if (p < 55) it.kind = SRC_IMM;
        else if (p < 95) it.kind = SRC_REG;
        else             it.kind = SRC_RSVD;
        p = $urandom_range(0, 99);
        if (p < 5)       it.srcr = REG_NONE;
        else if (p < 12) it.srcr = REG_RSP;
        else if (p < 20) it.srcr = REG_RIP;
        else             it.srcr = pick_gpr();
        it.imm = rand_word();
        return it;
    endfunction

    // Offer one request and hold it until accepted, then record what it owes.
    task automatic send_instr(input t_instr it);
        // never pop a stack word that was not written: turn it into a push
        if (!halt_st && (it.cmd == OP_RET || (it.cmd == OP_POP && it.dst != REG_NONE)) &&
            !(it.kind == SRC_REG && it.srcr == REG_NONE) &&
            !stack_valid[slot_of(arch_regs[REG_RSP])])
            it.cmd = OP_PUSH;
        if (send_idle_en && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_cmd             <= it.cmd;
        i_dest_register   <= it.dst;
        i_source_kind     <= it.kind;
        i_source_register <= it.srcr;
        i_immediate       <= it.imm;
        do @(posedge i_clk); while (!o_ready);
        machine_results_q.push_back(execute_instr(it));
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        i_valid <= 1'b0;
        while (machine_results_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (machine_results_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, machine_results_q.size());
            errors++;
            machine_results_q.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (recv_idle_en) begin
            i_ready <= ($urandom_range(0, 99) >= 6);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (machine_results_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, status %0d", $time, o_status);
                errors++;
            end else begin
                want_res = machine_results_q.pop_front();
                results_checked++;
                if (o_status !== want_res.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want_res.status, o_status);
                    errors++;
                end
                if (o_dest_value !== want_res.dest_value) begin
                    $display("%0t: dest_value expected %h, got %h",
                             $time, want_res.dest_value, o_dest_value);
                    errors++;
                end
                if (o_next_rip !== want_res.next_rip) begin
                    $display("%0t: next_rip expected %h, got %h",
                             $time, want_res.next_rip, o_next_rip);
                    errors++;
                end
                if (o_zero_flag !== want_res.zero_flag) begin
                    $display("%0t: zero_flag expected %b, got %b",
                             $time, want_res.zero_flag, o_zero_flag);
                    errors++;
                end
                if (o_sign_flag !== want_res.sign_flag) begin
                    $display("%0t: sign_flag expected %b, got %b",
                             $time, want_res.sign_flag, o_sign_flag);
                    errors++;
                end
            end
        end
    end

    task automatic test_arith();
        send_instr(instr(OP_MOV, REG_RAX, SRC_IMM, REG_RAX, '1));
        send_instr(instr(OP_ADD, REG_RAX, SRC_IMM, REG_RAX, 64'd1));   // wraps to zero
        send_instr(instr(OP_SUB, REG_RAX, SRC_IMM, REG_RAX, 64'd1));
        send_instr(instr(OP_MOV, REG_RBX, SRC_REG, REG_RAX, '0));
        send_instr(instr(OP_CMP, REG_RBX, SRC_REG, REG_RAX, '0));
        send_instr(instr(OP_MOV, REG_RCX, SRC_RSVD, REG_RAX, 64'hDEAD_BEEF));
        send_instr(instr(OP_MOV, REG_RBP, SRC_IMM, REG_RAX, {1'b1, 63'd0}));
        send_instr(instr(OP_CMP, REG_RBP, SRC_IMM, REG_RAX, '0));
        wait_idle();
    endtask

    task automatic test_jumps();
        send_instr(instr(OP_JE,  REG_NONE, SRC_IMM, REG_RAX, 64'h1000));  // not taken
        send_instr(instr(OP_JNE, REG_NONE, SRC_IMM, REG_RAX, 64'h1000));
        send_instr(instr(OP_CMP, REG_RAX, SRC_REG, REG_RAX, '0));
        send_instr(instr(OP_JE,  REG_RAX, SRC_REG, REG_RBX, '0));
        send_instr(instr(OP_JMP, REG_RIP, SRC_NONE, REG_RAX, '1));
        wait_idle();
    endtask

    task automatic test_stack();
        send_instr(instr(OP_PUSH, REG_RAX, SRC_NONE, REG_RAX, '0));   // rsp wraps below zero
        send_instr(instr(OP_CALL, REG_NONE, SRC_IMM, REG_RAX, 64'h40));
        send_instr(instr(OP_RET,  REG_NONE, SRC_NONE, REG_RAX, '0));
        send_instr(instr(OP_POP,  REG_RDX, SRC_NONE, REG_RAX, '0));
        send_instr(instr(OP_PUSH, REG_RSP, SRC_NONE, REG_RAX, '0));
        send_instr(instr(OP_POP,  REG_RSP, SRC_NONE, REG_RAX, '0));
        wait_idle();
    endtask

    task automatic test_errors();
        send_instr(instr(OP_MOV,    REG_NONE, SRC_IMM, REG_RAX, 64'd5));
        send_instr(instr(OP_UNK_HI, REG_NONE, SRC_IMM, REG_RAX, 64'd5));
        send_instr(instr(OP_ADD,    REG_RAX, SRC_REG, REG_NONE, '0));
        send_instr(instr(OP_RET,    REG_NONE, SRC_REG, REG_NONE, '0));
        send_instr(instr(OP_UNK_LO, REG_RAX, SRC_IMM, REG_RAX, '1));
        wait_idle();
    endtask

    task automatic test_random_program(int unsigned n_items);
        int unsigned sent;
        int unsigned depth;
        int unsigned k;
        t_instr      it;
        sent = 0;
        while (sent < n_items) begin
            // one long stretch with no idling on either side
            send_idle_en = !(sent >= n_items / 3 && sent < n_items / 3 + 150);
            recv_idle_en = send_idle_en;
            if ($urandom_range(0, 99) < 20) begin
                depth = $urandom_range(1, 6);
                for (k = 0; k < depth; k++) begin
                    it     = random_instr();
                    it.cmd = ($urandom_range(0, 3) == 0) ? OP_CALL : OP_PUSH;
                    send_instr(it);
                end
                for (k = 0; k < depth; k++) begin
                    it     = random_instr();
                    it.cmd = ($urandom_range(0, 3) == 0) ? OP_RET : OP_POP;
                    it.dst = pick_gpr();
                    send_instr(it);
                end
                sent += 2 * depth;
            end else begin
                send_instr(random_instr());
                sent++;
            end
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_backpressure();
        int unsigned k;
        send_idle_en = 1'b0;
        hold_req++;
        for (k = 0; k < BURST_ITEMS; k++)
            send_instr(random_instr());
        send_idle_en = 1'b1;
        wait_idle();
    endtask

    task automatic test_halt();
        send_instr(instr(OP_HLT, REG_RAX, SRC_NONE, REG_RAX, '0));
        send_instr(instr(OP_MOV, REG_RAX, SRC_IMM, REG_RAX, 64'd7));
        send_instr(instr(OP_HLT, REG_NONE, SRC_REG, REG_NONE, '0));
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_arith();
        test_jumps();
        test_stack();
        test_errors();
        test_random_program(RANDOM_ITEMS);
        test_backpressure();
        test_halt();
        $display("Ran %0d instructions, checked %0d results, %0d stack writes, %0d reads.",
                 items_sent, results_checked, stack_writes, stack_reads);
        $display("Covered arithmetic, jumps, stack wrap, error codes, halt and stalls.");
        if (errors == 0)
            $display("PASS register_machine_instruction_executor_top");
        else
            $display("FAIL register_machine_instruction_executor_top");
        $finish;
    end

    initial begin
        #400_000;
        $display("Timed out with %0d results outstanding", machine_results_q.size());
        $display("FAIL register_machine_instruction_executor_top");
        $finish;
    end

endmodule
